>>> rtl/olasd_pkg.sv
// Package for the ordered list block: request codes, cell control struct and
// default sizes. Used by olasd_cell and ordered_list_append_search_delete.
package olasd_pkg;

    localparam int DEF_LIST_DEPTH = 16;
    localparam int ENTRY_W        = 32;
    localparam int COUNT_OUT_W    = 5;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_SEARCH = 2'd1,
        OP_DELETE = 2'd2
    } op_t;

    // Per-transaction control broadcast to every cell of the chain.
    typedef struct packed {
        logic do_append;
        logic do_delete;
    } cell_ctrl_t;

endpackage

>>> rtl/ordered_list_append_search_delete.sv
// Top level of the ordered list with append, search and delete requests.
// Builds a chain of olasd_cell instances and keeps the fill count; uses olasd_pkg.
//
//  channel | direction | ports                                      | handshake
//  input   | in        | s_opcode, s_value                          | s_valid / s_ready
//  result  | out       | m_hit, m_full_reject, m_entry_count        | m_valid / m_ready
//
// Each transaction is resolved combinationally: all cells compare in parallel and
// the first-match flag ripples along the chain, which sets the cycle time.
// The result appears in the output register in the cycle after acceptance.
// One transaction per cycle is sustained while m_ready stays high; a stalled
// result blocks the input only while the output register is occupied.
// Synchronous reset empties the list; entries need no clearing.
module ordered_list_append_search_delete
    import olasd_pkg::*;
#(
    parameter int LIST_DEPTH = DEF_LIST_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_opcode,
    input  logic signed [ENTRY_W-1:0]     s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_hit,
    output logic                          m_full_reject,
    output logic [COUNT_OUT_W-1:0]        m_entry_count
);

    localparam int COUNT_W = $clog2(LIST_DEPTH + 1);
    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(LIST_DEPTH);

    logic [COUNT_W-1:0]        count_reg;
    logic [COUNT_W-1:0]        count_next;
    logic                      m_valid_reg;
    logic                      m_valid_next;
    logic                      m_hit_reg;
    logic                      m_hit_next;
    logic                      m_full_reject_reg;
    logic                      m_full_reject_next;
    logic [COUNT_OUT_W-1:0]    m_entry_count_reg;
    logic [COUNT_OUT_W-1:0]    m_entry_count_next;

    logic                      accept;
    logic                      full;
    logic                      any_found;
    cell_ctrl_t                ctrl;
    logic                      found_chain [LIST_DEPTH+1];
    logic signed [ENTRY_W-1:0] entries     [LIST_DEPTH];

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign full    = count_reg == FULL_COUNT;

    assign found_chain[0] = 1'b0;
    assign any_found      = found_chain[LIST_DEPTH];

    for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
        logic signed [ENTRY_W-1:0] right;
        if (i == LIST_DEPTH - 1) begin : g_last
            assign right = entries[i];
        end else begin : g_mid
            assign right = entries[i+1];
        end
        olasd_cell #(
            .COUNT_W (COUNT_W),
            .INDEX   (i)
        ) u_cell (
            .aclk        (aclk),
            .key         (s_value),
            .ctrl        (ctrl),
            .count       (count_reg),
            .found_in    (found_chain[i]),
            .right_entry (right),
            .entry       (entries[i]),
            .found_out   (found_chain[i+1])
        );
    end

    always_comb begin
        ctrl               = '0;
        count_next         = count_reg;
        m_hit_next         = 1'b0;
        m_full_reject_next = 1'b0;
        case (s_opcode)
            OP_APPEND: begin
                if (full) begin
                    m_full_reject_next = 1'b1;
                end else begin
                    ctrl.do_append = accept;
                    count_next     = count_reg + COUNT_W'(1);
                    m_hit_next     = 1'b1;
                end
            end
            OP_SEARCH: begin
                m_hit_next = any_found;
            end
            OP_DELETE: begin
                if (any_found) begin
                    ctrl.do_delete = accept;
                    count_next     = count_reg - COUNT_W'(1);
                    m_hit_next     = 1'b1;
                end
            end
            default: begin
                // Unused code: no change, plain result.
            end
        endcase
        m_entry_count_next = COUNT_OUT_W'(count_next);
        m_valid_next       = accept || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_hit_reg         <= m_hit_next;
            m_full_reject_reg <= m_full_reject_next;
            m_entry_count_reg <= m_entry_count_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_hit         = m_hit_reg;
    assign m_full_reject = m_full_reject_reg;
    assign m_entry_count = m_entry_count_reg;

    // The fill count never passes the list depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_COUNT)
        else $error("fill count exceeds list depth");

    // A refused append never reports a hit.
    a_reject_no_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_hit_reg && m_full_reject_reg))
        else $error("hit and full reject both set");

    // The pending result always reports the current fill count.
    a_count_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_entry_count_reg == COUNT_OUT_W'(count_reg)))
        else $error("result count differs from fill count");

    // An accepted transaction always produces a pending result.
    a_accept_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg)
        else $error("accepted transaction lost its result");

endmodule

>>> rtl/olasd_cell.sv
// One storage cell of the ordered list: holds one entry, compares it with
// the key and passes the first-match flag to its right neighbor. Uses olasd_pkg.
module olasd_cell
    import olasd_pkg::*;
#(
    parameter int COUNT_W = 5,
    parameter int INDEX   = 0
) (
    input  logic                      aclk,
    input  logic signed [ENTRY_W-1:0] key,
    input  cell_ctrl_t                ctrl,
    input  logic        [COUNT_W-1:0] count,
    input  logic                      found_in,
    input  logic signed [ENTRY_W-1:0] right_entry,
    output logic signed [ENTRY_W-1:0] entry,
    output logic                      found_out
);

    localparam logic [COUNT_W-1:0] MY_INDEX = COUNT_W'(INDEX);

    logic signed [ENTRY_W-1:0] entry_reg;
    logic signed [ENTRY_W-1:0] entry_next;
    logic                      active;
    logic                      is_tail;

    assign active    = MY_INDEX < count;
    assign is_tail   = MY_INDEX == count;
    assign found_out = found_in | (active & (entry_reg == key));
    assign entry     = entry_reg;

    // On delete, every cell from the first match onward takes its right
    // neighbor's value; the slot that falls out of the list keeps garbage.
    always_comb begin
        entry_next = entry_reg;
        if (ctrl.do_append && is_tail) begin
            entry_next = key;
        end else if (ctrl.do_delete && found_out) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule
